>>> rtl/core/assert_macros.svh
// Assertion macros for the range alarm core.
// No dependencies; the including module must provide clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> rtl/core/rarl_pkg.sv
// Shared types and constants for the range alarm rate limiter.
// No dependencies.
package rarl_pkg;

   localparam int CHANNELS_DEFAULT = 32;
   localparam int CH_W             = 5;
   localparam int VALUE_W          = 32;
   localparam int IVL_W            = 16;
   localparam int CNT_W            = 16;

   localparam logic CMD_CHECK = 1'b0;
   localparam logic CMD_LOAD  = 1'b1;

   // holdoff codes for latch mode
   localparam logic signed [IVL_W-1:0] HOLD_BELOW = -16'sd100;
   localparam logic signed [IVL_W-1:0] HOLD_ABOVE = -16'sd101;
   localparam logic [CNT_W-1:0]        COUNT_MAX  = 16'hFFFF;

   typedef struct packed {
      logic                      cmd;
      logic [CH_W-1:0]           channel;
      logic signed [VALUE_W-1:0] value;
      logic                      startup_hold;
      logic signed [VALUE_W-1:0] lower_limit_in;
      logic signed [VALUE_W-1:0] upper_limit_in;
      logic signed [IVL_W-1:0]   interval_in;
      logic [CNT_W-1:0]          budget_in;
   } req_type;

   typedef struct packed {
      logic [CH_W-1:0] alarm_channel;
      logic            below_warning;
      logic            above_warning;
   } rsp_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] low_limit;
      logic signed [VALUE_W-1:0] high_limit;
      logic signed [IVL_W-1:0]   interval;
      logic [CNT_W-1:0]          budget;
   } cfg_entry_type;

   typedef struct packed {
      logic signed [IVL_W-1:0] holdoff;
      logic [CNT_W-1:0]        warnings;
   } dyn_entry_type;

endpackage

>>> rtl/core/range_alarm_rate_limiter.sv
// Range alarm rate limiter: per-channel limit check with warning budget and holdoff.
// Depends on rarl_pkg and assert_macros.svh.
//
// Usage:
//  - Drive req_item and raise start; the item is taken at an edge where start is high
//    and busy is low. cmd CMD_LOAD writes a channel's limits, interval and budget and
//    clears its holdoff and warning count; cmd CMD_CHECK checks one sample.
//  - For each item, the accept edge reads the channel's entries from the settings
//    memory and the state memory, and the next edge evaluates and writes the state
//    back. busy is high for a single cycle between those edges, so no new item is taken before the last is done.
//  - A check that raises a warning gives one result: rsp_strobe is high for exactly one
//    cycle, starting the cycle after the evaluation edge, with rsp_item alongside. It
//    must be taken then; there is no back-pressure. Loads and quiet checks give none.
//  - Read and write-back of the same channel never overlap: busy blocks a new read at
//    the write edge, so no forwarding is needed.
//  - Reset clears a per-channel valid vector at once; a channel never loaded reads its
//    interval as zero (disabled). Channels at or beyond CHANNELS are ignored.
module range_alarm_rate_limiter #(
   parameter int CHANNELS = rarl_pkg::CHANNELS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  rarl_pkg::req_type req_item,
   output logic              rsp_strobe,
   output rarl_pkg::rsp_type rsp_item
);

`include "assert_macros.svh"

   localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   // storage
   rarl_pkg::cfg_entry_type cfg_mem [CHANNELS];
   rarl_pkg::dyn_entry_type dyn_mem [CHANNELS];
   logic [CHANNELS-1:0]     valid_ff;

   // pipeline registers
   logic                    exec_ff;
   rarl_pkg::req_type       item_ff;
   logic                    in_range_ff;
   logic                    valid_rd_ff;
   rarl_pkg::cfg_entry_type cfg_rd_ff;
   rarl_pkg::dyn_entry_type dyn_rd_ff;
   logic                    rsp_strobe_ff, rsp_strobe_in;
   rarl_pkg::rsp_type       rsp_item_ff, rsp_item_in;

   logic                    accept;
   logic [rarl_pkg::CH_W+AW-1:0] req_wide, exe_wide;
   logic [AW-1:0]           req_addr, exe_addr;
   logic                    req_in_range;

   // evaluation
   logic                          cfg_we, dyn_we;
   rarl_pkg::dyn_entry_type       dyn_wd;
   logic signed [rarl_pkg::IVL_W-1:0] iv, h;
   logic                          below, above;
   logic [rarl_pkg::CNT_W:0]      cnt_sum;

   assign accept       = start && !busy;
   assign busy         = exec_ff;
   assign req_wide     = {{AW{1'b0}}, req_item.channel};
   assign exe_wide     = {{AW{1'b0}}, item_ff.channel};
   assign req_addr     = req_wide[AW-1:0];
   assign exe_addr     = exe_wide[AW-1:0];
   assign req_in_range = 32'(req_item.channel) < CHANNELS;

   always_ff @(posedge clock) begin
      if (reset) begin
         exec_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         exec_ff       <= accept;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cfg_we) begin
         valid_ff[exe_addr] <= 1'b1;
      end
   end

   // read port: item and both entries captured on accept
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff     <= req_item;
         in_range_ff <= req_in_range;
         valid_rd_ff <= valid_ff[req_addr];
         cfg_rd_ff   <= cfg_mem[req_addr];
         dyn_rd_ff   <= dyn_mem[req_addr];
      end
   end

   // write port
   always_ff @(posedge clock) begin
      if (cfg_we) begin
         cfg_mem[exe_addr] <= '{low_limit:  item_ff.lower_limit_in,
                                high_limit: item_ff.upper_limit_in,
                                interval:   item_ff.interval_in,
                                budget:     item_ff.budget_in};
      end
      if (dyn_we) begin
         dyn_mem[exe_addr] <= dyn_wd;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   always_comb begin
      cfg_we        = 1'b0;
      dyn_we        = 1'b0;
      dyn_wd        = dyn_rd_ff;
      below         = 1'b0;
      above         = 1'b0;
      rsp_strobe_in = 1'b0;
      // unloaded channel reads as disabled; its state entry is never used
      iv            = valid_rd_ff ? cfg_rd_ff.interval : '0;
      h             = dyn_rd_ff.holdoff;
      cnt_sum       = '0;
      rsp_item_in   = '{alarm_channel: item_ff.channel, below_warning: 1'b0,
                        above_warning: 1'b0};

      if (exec_ff && in_range_ff) begin
         if (item_ff.cmd == rarl_pkg::CMD_LOAD) begin
            cfg_we = 1'b1;
            dyn_we = 1'b1;
            dyn_wd = '0;
         end else if (!item_ff.startup_hold && iv != '0) begin
            if (h > 0) begin
               dyn_we         = 1'b1;
               dyn_wd.holdoff = h - 16'sd1;
            end else if (!(cfg_rd_ff.budget != '0 &&
                           dyn_rd_ff.warnings >= cfg_rd_ff.budget)) begin
               if ($signed(item_ff.value) < $signed(cfg_rd_ff.low_limit)) begin
                  if (h == '0) begin
                     below = 1'b1;
                     h     = (iv > 0) ? iv - 16'sd1 : rarl_pkg::HOLD_BELOW;
                  end
                  if (h == rarl_pkg::HOLD_ABOVE) begin
                     h = '0;
                  end
               end
               if ($signed(item_ff.value) > $signed(cfg_rd_ff.high_limit)) begin
                  if (h == '0) begin
                     above = 1'b1;
                     h     = (iv > 0) ? iv - 16'sd1 : rarl_pkg::HOLD_ABOVE;
                  end
                  if (h == rarl_pkg::HOLD_BELOW) begin
                     h = '0;
                  end
               end
               // both sides in one sample may add two; saturating
               cnt_sum = {1'b0, dyn_rd_ff.warnings} + 17'(below) + 17'(above);
               dyn_we          = 1'b1;
               dyn_wd.holdoff  = h;
               dyn_wd.warnings = cnt_sum[rarl_pkg::CNT_W] ? rarl_pkg::COUNT_MAX
                                                          : cnt_sum[rarl_pkg::CNT_W-1:0];
               rsp_strobe_in   = below || above;
               rsp_item_in.below_warning = below;
               rsp_item_in.above_warning = above;
            end
         end
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

   `ASSERT_NXT(a_accept_busy, accept, busy)
   `ASSERT_NXT(a_single_exec, exec_ff, !busy)
   `ASSERT_IMP(a_rsp_after_exec, rsp_strobe_ff, $past(exec_ff))
   `ASSERT_IMP(a_rsp_has_warning,
               rsp_strobe_ff, rsp_item_ff.below_warning || rsp_item_ff.above_warning)
   `ASSERT_IMP(a_rsp_from_check, rsp_strobe_ff, $past(item_ff.cmd) == rarl_pkg::CMD_CHECK)

endmodule

>>> verif/tb_range_alarm_rate_limiter.sv
// Testbench for range_alarm_rate_limiter: directed and random items, with alarms predicted
// and checked in order. Depends on rarl_pkg and the range_alarm_rate_limiter RTL only.
module tb_range_alarm_rate_limiter;
   timeunit 1ns;
   timeprecision 1ps;

   import rarl_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int MAX_REPORTS  = 10;
   localparam int DRAIN_CYCLES = 10;
   localparam int IDLE_PERCENT = 19;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_item = '0;
   logic    rsp_strobe;
   rsp_type rsp_item;

   // per-channel copy of the block's tables
   logic signed [VALUE_W-1:0] low_lim  [CHANNELS_DEFAULT] = '{default: '0};
   logic signed [VALUE_W-1:0] high_lim [CHANNELS_DEFAULT] = '{default: '0};
   logic signed [IVL_W-1:0]   ivl      [CHANNELS_DEFAULT] = '{default: '0};
   logic [CNT_W-1:0]          budget   [CHANNELS_DEFAULT] = '{default: '0};
   logic signed [IVL_W-1:0]   holdoff  [CHANNELS_DEFAULT] = '{default: '0};
   logic [CNT_W-1:0]          warn_cnt [CHANNELS_DEFAULT] = '{default: '0};

   rsp_type pending_alarms[$];
   int      mismatches = 0;
   int      cycles = 0;
   bit      gaps_on = 1'b1;

   range_alarm_rate_limiter #(.CHANNELS(CHANNELS_DEFAULT)) DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("simulation failed");
         $finish;
      end
   end

   function automatic void bump_count(input int ch);
      if (warn_cnt[ch] != COUNT_MAX)
         warn_cnt[ch] = warn_cnt[ch] + 1'b1;
   endfunction

   // Works out the alarm, if any, that an accepted item raises.
   function automatic void predict_alarm(input req_type it);
      int                      ch;
      logic signed [IVL_W-1:0] h;
      logic                    below;
      logic                    above;
      rsp_type                 r;
      ch = it.channel;
      if (it.cmd == CMD_LOAD) begin
         low_lim[ch]  = it.lower_limit_in;
         high_lim[ch] = it.upper_limit_in;
         ivl[ch]      = it.interval_in;
         budget[ch]   = it.budget_in;
         holdoff[ch]  = '0;
         warn_cnt[ch] = '0;
         return;
      end
      if (it.startup_hold || ivl[ch] == 0)
         return;
      h = holdoff[ch];
      if (h > 0) begin
         holdoff[ch] = h - 16'sd1;
         return;
      end
      if (budget[ch] != 0 && warn_cnt[ch] >= budget[ch])
         return;
      below = 1'b0;
      above = 1'b0;
      if ($signed(it.value) < $signed(low_lim[ch])) begin
         if (h == 0) begin
            below = 1'b1;
            bump_count(ch);
            h = (ivl[ch] > 0) ? ivl[ch] - 16'sd1 : HOLD_BELOW;
         end
         if (h == HOLD_ABOVE)
            h = '0;
      end
      if ($signed(it.value) > $signed(high_lim[ch])) begin
         if (h == 0) begin
            above = 1'b1;
            bump_count(ch);
            h = (ivl[ch] > 0) ? ivl[ch] - 16'sd1 : HOLD_ABOVE;
         end
         if (h == HOLD_BELOW)
            h = '0;
      end
      holdoff[ch] = h;
      if (below || above) begin
         r.alarm_channel = ch[CH_W-1:0];
         r.below_warning = below;
         r.above_warning = above;
         pending_alarms.push_back(r);
      end
   endfunction

   function automatic req_type load_item(input int ch, input logic signed [31:0] lo,
                                         input logic signed [31:0] hi,
                                         input logic signed [15:0] iv, input logic [15:0] bud);
      req_type it;
      it.cmd            = CMD_LOAD;
      it.channel        = ch[CH_W-1:0];
      it.value          = $urandom();
      it.startup_hold   = 1'($urandom_range(0, 1));
      it.lower_limit_in = lo;
      it.upper_limit_in = hi;
      it.interval_in    = iv;
      it.budget_in      = bud;
      return it;
   endfunction

   function automatic req_type sample_item(input int ch, input logic signed [31:0] v,
                                           input logic hold);
      req_type it;
      it.cmd            = CMD_CHECK;
      it.channel        = ch[CH_W-1:0];
      it.value          = v;
      it.startup_hold   = hold;
      it.lower_limit_in = $urandom();
      it.upper_limit_in = $urandom();
      it.interval_in    = 16'($urandom());
      it.budget_in      = 16'($urandom());
      return it;
   endfunction

   // Entered and left at a falling edge.
   task automatic send_item(input req_type it);
      if (gaps_on)
         while ($urandom_range(0, 99) < IDLE_PERCENT) begin
            start = 1'b0;
            @(negedge clock);
         end
      start    = 1'b1;
      req_item = it;
      do @(posedge clock); while (busy !== 1'b0);
      predict_alarm(it);
      @(negedge clock);
      start = 1'b0;
   endtask

   task automatic test_disabled_and_hold;
      send_item(sample_item(0, 32'sh7FFF_FFFF, 1'b0));   // never loaded
      send_item(load_item(1, -256, 256, 2, 3));
      send_item(sample_item(1, -1000, 1'b1));            // startup hold, no countdown
   endtask

   task automatic test_limit_extremes;
      send_item(load_item(31, 32'sh8000_0000, 32'sh7FFF_FFFF, 1, 0));
      send_item(sample_item(31, 32'sh8000_0000, 1'b0));
      send_item(sample_item(31, 32'sh7FFF_FFFF, 1'b0));
      // crossed limits, interval one: both sides in one item
      send_item(load_item(30, 32'sh7FFF_FFFF, 32'sh8000_0000, 1, 0));
      send_item(sample_item(30, 0, 1'b0));
   endtask

   task automatic test_holdoff_and_budget;
      send_item(sample_item(1, -257, 1'b0));
      send_item(sample_item(1, -257, 1'b0));
      send_item(sample_item(1, 300, 1'b0));
      send_item(sample_item(1, 300, 1'b0));
      send_item(sample_item(1, 0, 1'b0));
      send_item(sample_item(1, -300, 1'b0));
      send_item(sample_item(1, 300, 1'b0));
      send_item(sample_item(1, 300, 1'b0));              // budget spent
      send_item(load_item(4, 0, 0, 16'sh7FFF, 16'hFFFF));
      send_item(sample_item(4, 1, 1'b0));
   endtask

   task automatic test_latch_mode;
      send_item(load_item(3, 0, 0, 16'sh8000, 0));
      send_item(sample_item(3, -1, 1'b0));
      send_item(sample_item(3, -5, 1'b0));
      send_item(sample_item(3, 5, 1'b0));                // rearms, silent
      send_item(sample_item(3, 5, 1'b0));
      send_item(sample_item(3, -1, 1'b0));
      send_item(sample_item(3, -1, 1'b0));
   endtask

   // Mostly a few channels, loads now and then, samples close to the limits.
   task automatic test_random_traffic(input int count, input bit with_gaps);
      int                  ch;
      int                  pick;
      logic signed [31:0]  lo;
      logic signed [31:0]  hi;
      logic signed [31:0]  v;
      logic signed [15:0]  iv;
      logic [15:0]         bud;
      gaps_on = with_gaps;
      for (int n = 0; n < count; n++) begin
         ch = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 3) : $urandom_range(0, 31);
         if ($urandom_range(0, 99) < 10) begin
            pick = $urandom_range(0, 99);
            lo   = $signed($urandom_range(0, 2000)) - 1000;
            hi   = lo + $signed($urandom_range(0, 400));
            if (pick < 10) begin
               lo = $urandom();
               hi = $urandom();
            end else if (pick < 20) begin
               v  = lo;
               lo = hi;
               hi = v;
            end
            iv   = ($urandom_range(0, 99) < 85) ? 16'($signed($urandom_range(0, 8)) - 4)
                                                  : 16'($urandom());
            pick = $urandom_range(0, 99);
            bud  = (pick < 40) ? 16'd0 : (pick < 85) ? 16'($urandom_range(1, 6))
                                                     : 16'($urandom());
            send_item(load_item(ch, lo, hi, iv, bud));
         end else begin
            v = $urandom_range(0, 1) ? low_lim[ch] : high_lim[ch];
            if ($urandom_range(0, 99) < 75)
               v = v + ($signed($urandom_range(0, 6)) - 3);
            else
               v = $urandom();
            send_item(sample_item(ch, v, $urandom_range(0, 99) < 5));
         end
      end
   endtask

   // Sender holds off until every alarm has come.
   task automatic test_drain_pause;
      start = 1'b0;
      while (pending_alarms.size() != 0)
         @(negedge clock);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_alarms.size() == 0) begin
            if (mismatches < MAX_REPORTS)
               $display("unexpected alarm: ch %0d below %0b above %0b",
                        rsp_item.alarm_channel, rsp_item.below_warning,
                        rsp_item.above_warning);
            mismatches++;
         end else begin
            want = pending_alarms.pop_front();
            if (rsp_item.alarm_channel !== want.alarm_channel
                || rsp_item.below_warning !== want.below_warning
                || rsp_item.above_warning !== want.above_warning) begin
               if (mismatches < MAX_REPORTS)
                  $display("alarm mismatch: want ch %0d b %0b a %0b, got ch %0d b %0b a %0b",
                           want.alarm_channel, want.below_warning, want.above_warning,
                           rsp_item.alarm_channel, rsp_item.below_warning,
                           rsp_item.above_warning);
               mismatches++;
            end
         end
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_disabled_and_hold();
      test_limit_extremes();
      test_holdoff_and_budget();
      test_latch_mode();
      test_random_traffic(700, 1'b1);
      test_drain_pause();
      test_random_traffic(300, 1'b0);
      test_random_traffic(600, 1'b1);

      for (int n = 0; n < 200 && pending_alarms.size() != 0; n++)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_alarms.size() != 0)
         $display("%0d expected alarms never came", pending_alarms.size());
      if (mismatches == 0 && pending_alarms.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
